FILE: design/wall_follower_maze_step_defines.svh
// assertion macros shared by the maze walker modules
`ifndef WALL_FOLLOWER_MAZE_STEP_DEFINES_SVH
`define WALL_FOLLOWER_MAZE_STEP_DEFINES_SVH

`ifndef SYNTHESIS

// concurrent check, disabled while reset is asserted
`define WFM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wfm check failed");

// concurrent check that also holds during reset
`define WFM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wfm check failed");

`else

`define WFM_ASSERT(lbl, clk, rst_n, prop)
`define WFM_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: design/wfm_pkg.sv
// shared types, constants and helper functions for the maze walker
`timescale 1ns / 1ps

package wfm_pkg;

  // maze geometry
  localparam int unsigned MAX_SIDE = 64;
  localparam int unsigned SIDE_W   = $clog2(MAX_SIDE);
  localparam int unsigned ADDR_W   = 2 * SIDE_W;
  localparam int unsigned DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CNT_W    = 16;

  localparam logic [CFG_W-1:0] SIDE_MIN   = 7'd3;
  localparam logic [CFG_W-1:0] SIDE_MAX   = 7'd64;
  localparam logic [CFG_W-1:0] SIDE_RESET = 7'd12;
  localparam logic [CNT_W-1:0] CNT_MAX    = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_HEIGHT = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    H_NONE  = 3'd0,
    H_EAST  = 3'd1,
    H_WEST  = 3'd2,
    H_SOUTH = 3'd3,
    H_NORTH = 3'd4
  } heading_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXIT     = 2'd1,
    ST_NO_EXIT  = 2'd2,
    ST_FINISHED = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic latch;       // capture the input transaction
    logic exec;        // evaluate the item, commit if no maze reads are needed
    logic rd_ud;       // keep left/right cells, read up/down cells
    logic commit_mem;  // commit a step decided from maze reads
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_reads;  // interior step, neighbors come from the maze store
    logic out_busy;     // result register holds a transaction not taken this cycle
  } ctrl_sts_t;

  // limit a configured side length to the usable range
  function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] res;
    res = v;
    if (v < SIDE_MIN) begin
      res = SIDE_MIN;
    end else if (v > SIDE_MAX) begin
      res = SIDE_MAX;
    end
    return res;
  endfunction

  // right-hand rule: turn order follows the last heading
  function automatic heading_e pick_heading(input heading_e h, input logic up,
                                            input logic down, input logic left,
                                            input logic right);
    heading_e res;
    res = H_NONE;
    case (h)
      H_EAST:  res = down  ? H_SOUTH : right ? H_EAST  : up    ? H_NORTH : H_WEST;
      H_WEST:  res = up    ? H_NORTH : left  ? H_WEST  : down  ? H_SOUTH : H_EAST;
      H_SOUTH: res = left  ? H_WEST  : down  ? H_SOUTH : right ? H_EAST  : H_NORTH;
      H_NORTH: res = right ? H_EAST  : up    ? H_NORTH : left  ? H_WEST  : H_SOUTH;
      default: res = H_NONE;
    endcase
    return res;
  endfunction

endpackage

FILE: design/wfm_ctrl.sv
// sequencing state machine for the maze walker
`timescale 1ns / 1ps
`include "wall_follower_maze_step_defines.svh"

module wfm_ctrl
  import wfm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_FETCH  = 2'd2,
    S_DECIDE = 2'd3
  } state_e;

  state_e state_q, state_d;

  // take a transaction only when idle and the result register is free
  assign in_ready_o = (state_q == S_IDLE) && !sts_i.out_busy;

  // commands decoded from state
  always_comb begin
    cmd_o            = '0;
    cmd_o.latch      = (state_q == S_IDLE) && in_valid_i && in_ready_o;
    cmd_o.exec       = (state_q == S_EXEC);
    cmd_o.rd_ud      = (state_q == S_FETCH);
    cmd_o.commit_mem = (state_q == S_DECIDE);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (cmd_o.latch) state_d = S_EXEC;
      S_EXEC:   state_d = sts_i.needs_reads ? S_FETCH : S_IDLE;
      S_FETCH:  state_d = S_DECIDE;
      S_DECIDE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // checks
  `WFM_ASSERT(a_fetch_then_decide, clk_i, rst_ni, (state_q == S_FETCH) |=> (state_q == S_DECIDE))
  `WFM_ASSERT(a_short_item_done, clk_i, rst_ni, (cmd_o.exec && !sts_i.needs_reads) |=> (state_q == S_IDLE))

endmodule

FILE: design/wfm_datapath.sv
// maze store, walker state, step decision and result register
`timescale 1ns / 1ps
`include "wall_follower_maze_step_defines.svh"

module wfm_datapath
  import wfm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input transaction
  input  logic [1:0]        action_i,
  input  logic [SIDE_W-1:0] row_i,
  input  logic [SIDE_W-1:0] col_i,
  input  logic              cell_open_i,
  // result transaction
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SIDE_W-1:0] pos_row_o,
  output logic [SIDE_W-1:0] pos_col_o,
  output logic [2:0]        heading_o,
  output logic [1:0]        status_o,
  output logic [CNT_W-1:0]  path_length_o,
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  // control
  input  ctrl_cmd_t         cmd_i,
  output ctrl_sts_t         sts_o
);

  // configuration
  logic [CFG_W-1:0] height_q, width_q;
  logic [CFG_W-1:0] h_eff, w_eff;

  // walker state
  logic [SIDE_W-1:0] walker_row_q, walker_col_q, start_row_q, start_col_q;
  heading_e          heading_q;
  logic [CNT_W-1:0]  step_count_q;
  logic              done_q;

  // captured item
  action_e           act_q;
  logic [SIDE_W-1:0] row_q, col_q;
  logic              open_q;

  // maze store and neighbor reads
  logic              maze_mem [DEPTH];
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic              rd_a_q, rd_b_q;
  logic [1:0]        rl_q;  // {right, left}

  // result register
  logic              out_valid_q;
  logic [SIDE_W-1:0] out_row_q, out_col_q;
  heading_e          out_head_q;
  status_e           out_status_q;
  logic [CNT_W-1:0]  out_len_q;

  // decision
  logic [CFG_W-1:0]  r7, c7;
  logic              oor, on_left, on_right, on_top, on_bottom, border, first, at_start;
  logic              up, down, left, right, do_move, commit;
  heading_e          base_head, pick;
  logic [SIDE_W-1:0] nxt_row, nxt_col, nxt_start_row, nxt_start_col;
  heading_e          nxt_head;
  logic [CNT_W-1:0]  nxt_cnt;
  logic              nxt_done;
  status_e           nxt_status;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= SIDE_RESET;
      width_q  <= SIDE_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_HEIGHT) height_q <= cfg_data_i;
      if (cfg_index_i == CFG_WIDTH)  width_q  <= cfg_data_i;
    end
  end

  assign h_eff = clamp_side(height_q);
  assign w_eff = clamp_side(width_q);

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_e'(action_i);
      row_q  <= row_i;
      col_q  <= col_i;
      open_q <= cell_open_i;
    end
  end

  // position classification
  assign r7        = {1'b0, walker_row_q};
  assign c7        = {1'b0, walker_col_q};
  assign oor       = (r7 >= h_eff) || (c7 >= w_eff);
  assign on_left   = (walker_col_q == '0);
  assign on_right  = (c7 == w_eff - 7'd1);
  assign on_top    = (walker_row_q == '0);
  assign on_bottom = (r7 == h_eff - 7'd1);
  assign border    = on_left || on_right || on_top || on_bottom;
  assign first     = (step_count_q == 16'd1);
  assign at_start  = (walker_row_q == start_row_q) && (walker_col_q == start_col_q);

  assign sts_o.needs_reads = (act_q == ACT_STEP) && !done_q && !oor && !border;
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

  assign commit = (cmd_i.exec && !sts_o.needs_reads) || cmd_i.commit_mem;

  // neighbor addresses: left/right first, then up/down
  always_comb begin
    if (cmd_i.rd_ud) begin
      rd_addr_a = {walker_row_q - 6'd1, walker_col_q};
      rd_addr_b = {walker_row_q + 6'd1, walker_col_q};
    end else begin
      rd_addr_a = {walker_row_q, walker_col_q + 6'd1};
      rd_addr_b = {walker_row_q, walker_col_q - 6'd1};
    end
  end

  // maze store, one write port and two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (act_q == ACT_WRITE)) begin
      maze_mem[{row_q, col_q}] <= open_q;
    end
    rd_a_q <= maze_mem[rd_addr_a];
    rd_b_q <= maze_mem[rd_addr_b];
    if (cmd_i.rd_ud) begin
      rl_q <= {rd_a_q, rd_b_q};
    end
  end

  // item evaluation
  always_comb begin
    nxt_row       = walker_row_q;
    nxt_col       = walker_col_q;
    nxt_start_row = start_row_q;
    nxt_start_col = start_col_q;
    nxt_head      = heading_q;
    nxt_cnt       = step_count_q;
    nxt_done      = done_q;
    nxt_status    = ST_OK;
    up            = 1'b0;
    down          = 1'b0;
    left          = 1'b0;
    right         = 1'b0;
    do_move       = 1'b0;
    base_head     = heading_q;
    pick          = H_NONE;
    case (act_q)
      ACT_START: begin
        nxt_row       = row_q;
        nxt_col       = col_q;
        nxt_start_row = row_q;
        nxt_start_col = col_q;
        nxt_head      = H_NONE;
        nxt_cnt       = 16'd1;
        nxt_done      = 1'b0;
      end
      ACT_STEP: begin
        if (done_q) begin
          nxt_status = ST_FINISHED;
        end else if (oor) begin
          nxt_done   = 1'b1;
          nxt_status = ST_NO_EXIT;
        end else if (border && !first) begin
          nxt_done   = 1'b1;
          nxt_status = at_start ? ST_NO_EXIT : ST_EXIT;
        end else if (border) begin
          // first step from the border heads inward, later sides win
          do_move = 1'b1;
          if (on_left) begin
            right     = 1'b1;
            base_head = H_NORTH;
          end
          if (on_right) begin
            left      = 1'b1;
            base_head = H_SOUTH;
          end
          if (on_top) begin
            down      = 1'b1;
            base_head = H_EAST;
          end
          if (on_bottom) begin
            up        = 1'b1;
            base_head = H_WEST;
          end
        end else begin
          do_move = 1'b1;
          right   = rl_q[1];
          left    = rl_q[0];
          up      = rd_a_q;
          down    = rd_b_q;
        end
      end
      default: begin
      end
    endcase

    if (do_move) begin
      pick = pick_heading(base_head, up, down, left, right);
      case (pick)
        H_EAST:  nxt_col = walker_col_q + 6'd1;
        H_WEST:  nxt_col = walker_col_q - 6'd1;
        H_SOUTH: nxt_row = walker_row_q + 6'd1;
        H_NORTH: nxt_row = walker_row_q - 6'd1;
        default: begin
        end
      endcase
      nxt_head = (pick != H_NONE) ? pick : base_head;
      if (step_count_q != CNT_MAX) nxt_cnt = step_count_q + 16'd1;
    end
  end

  // walker state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walker_row_q <= '0;
      walker_col_q <= '0;
      start_row_q  <= '0;
      start_col_q  <= '0;
      heading_q    <= H_NONE;
      step_count_q <= 16'd1;
      done_q       <= 1'b0;
    end else if (commit) begin
      walker_row_q <= nxt_row;
      walker_col_q <= nxt_col;
      start_row_q  <= nxt_start_row;
      start_col_q  <= nxt_start_col;
      heading_q    <= nxt_head;
      step_count_q <= nxt_cnt;
      done_q       <= nxt_done;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_row_q    <= nxt_row;
      out_col_q    <= nxt_col;
      out_head_q   <= nxt_head;
      out_status_q <= nxt_status;
      out_len_q    <= nxt_cnt;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pos_row_o     = out_row_q;
  assign pos_col_o     = out_col_q;
  assign heading_o     = out_head_q;
  assign status_o      = out_status_q;
  assign path_length_o = out_len_q;

  // checks
  `WFM_ASSERT(a_commit_into_free_slot, clk_i, rst_ni, commit |-> !out_valid_q)
  `WFM_ASSERT(a_commit_shows_result, clk_i, rst_ni, commit |=> out_valid_q)
  `WFM_ASSERT_ALWAYS(a_count_nonzero, clk_i, !rst_ni || step_count_q != 16'd0)

endmodule

FILE: design/wall_follower_maze_step.sv
// Right-hand wall follower: load a maze bitmap with write transactions, place the walker
// with a start transaction, then advance it one cell per step transaction. Every input
// transaction yields exactly one result transaction. Write, start, no-operation and border
// or terminal steps go from the execute state straight back to idle; interior steps pass
// through a fetch and a decide state as well, as the four neighbor cells are read through
// the two read ports of the maze memory (left/right, then up/down). The maze memory has no
// reset; cells must be written before the walker reads them. Configuration writes are
// always ready and take effect on the next step.
`timescale 1ns / 1ps

module wall_follower_maze_step
  import wfm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [SIDE_W-1:0] row_i,
  input  logic [SIDE_W-1:0] col_i,
  input  logic              cell_open_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SIDE_W-1:0] pos_row_o,
  output logic [SIDE_W-1:0] pos_col_o,
  output logic [2:0]        heading_o,
  output logic [1:0]        status_o,
  output logic [CNT_W-1:0]  path_length_o,
  // configuration channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer
  wfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // maze store and walker datapath
  wfm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .cell_open_i   (cell_open_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pos_row_o     (pos_row_o),
    .pos_col_o     (pos_col_o),
    .heading_o     (heading_o),
    .status_o      (status_o),
    .path_length_o (path_length_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
